### hdl/ctpt_pkg.sv
package ctpt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned MapBits    = 32;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned MapIdxW    = $clog2(MapBits);

  typedef enum logic [3:0] {
    OpInsert  = 4'd0,
    OpDelete  = 4'd1,
    OpLocate  = 4'd2,
    OpExists  = 4'd3,
    OpCount   = 4'd4,
    OpGet     = 4'd5,
    OpSet     = 4'd6,
    OpMin     = 4'd7,
    OpMinExcl = 4'd8,
    OpMinGt   = 4'd9,
    OpMax     = 4'd10,
    OpSetBit  = 4'd11,
    OpClear   = 4'd12,
    OpAll8    = 4'd13,
    OpThrough = 4'd14
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    WrNone   = 3'd0,
    WrInsert = 3'd1,
    WrDelete = 3'd2,
    WrPacket = 3'd3,
    WrMap    = 3'd4
  } wr_kind_e;

  typedef struct packed {
    logic [31:0]        addr;
    logic [15:0]        port;
    logic [7:0]         pkt;
    logic [MapBits-1:0] map;
  } entry_t;

  typedef struct packed {
    wr_kind_e        kind;
    logic [IdxW-1:0] idx;
    entry_t          data;
  } wr_cmd_t;

  typedef struct packed {
    logic               found;
    logic [IdxW-1:0]    hit_idx;
    logic [7:0]         hit_pkt;
    logic [MapBits-1:0] hit_map;
    logic [7:0]         head_pkt;
    logic               have_best;
    logic [7:0]         best;
  } scan_res_t;

endpackage

### hdl/ctpt_store.sv
module ctpt_store (
  input  logic                          clk_i,
  input  ctpt_pkg::wr_cmd_t             wr_i,
  input  logic [ctpt_pkg::IdxW-1:0]     rd_idx_i,
  output ctpt_pkg::entry_t              rd_o
);
  import ctpt_pkg::*;

  entry_t mem_q [TableDepth];

  // Entry storage: insert shifts every slot one place older, delete closes the gap.
  always_ff @(posedge clk_i) begin
    case (wr_i.kind)
      WrInsert: begin
        for (int i = TableDepth - 1; i > 0; i--) begin
          mem_q[i] <= mem_q[i-1];
        end
        mem_q[0] <= wr_i.data;
      end
      WrDelete: begin
        for (int i = 0; i < TableDepth - 1; i++) begin
          if (IdxW'(i) >= wr_i.idx) mem_q[i] <= mem_q[i+1];
        end
      end
      WrPacket: mem_q[wr_i.idx].pkt <= wr_i.data.pkt;
      WrMap:    mem_q[wr_i.idx].map <= wr_i.data.map;
      default: ;
    endcase
  end

  // Single read port used by the scan.
  assign rd_o = mem_q[rd_idx_i];

endmodule

### hdl/ctpt_scan.sv
module ctpt_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      step_i,
  input  logic [ctpt_pkg::IdxW-1:0] idx_i,
  input  ctpt_pkg::entry_t          entry_i,
  input  ctpt_pkg::op_e             op_i,
  input  logic [31:0]               addr_i,
  input  logic [15:0]               port_i,
  input  logic [7:0]                pk_i,
  output ctpt_pkg::scan_res_t       res_o
);
  import ctpt_pkg::*;

  logic found_q, have_q;
  logic [IdxW-1:0]    hit_idx_q;
  logic [7:0]         hit_pkt_q, head_pkt_q, best_q;
  logic [MapBits-1:0] hit_map_q;
  logic               match, better;

  // Shared compare unit: key match and one step of the min or max reduction.
  assign match = (entry_i.addr == addr_i) && (entry_i.port == port_i);

  always_comb begin
    case (op_i)
      OpMin:     better = !have_q || (entry_i.pkt < best_q);
      OpMax:     better = !have_q || (entry_i.pkt > best_q);
      OpMinExcl: better = (entry_i.pkt != pk_i) && (!have_q || (entry_i.pkt < best_q));
      OpMinGt:   better = (entry_i.pkt > pk_i) && (!have_q || (entry_i.pkt < best_q));
      default:   better = 1'b0;
    endcase
  end

  // Flags of the reduction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      have_q  <= 1'b0;
    end else if (clear_i) begin
      found_q <= 1'b0;
      have_q  <= 1'b0;
    end else if (step_i) begin
      if (match) found_q <= 1'b1;
      if (better) have_q <= 1'b1;
    end
  end

  // Captured values; the first match is the newest entry.
  always_ff @(posedge clk_i) begin
    if (step_i && !clear_i) begin
      if (match && !found_q) begin
        hit_idx_q <= idx_i;
        hit_pkt_q <= entry_i.pkt;
        hit_map_q <= entry_i.map;
      end
      if (idx_i == '0) head_pkt_q <= entry_i.pkt;
      if (better) best_q <= entry_i.pkt;
    end
  end

  assign res_o = '{found: found_q, hit_idx: hit_idx_q, hit_pkt: hit_pkt_q,
                   hit_map: hit_map_q, head_pkt: head_pkt_q,
                   have_best: have_q, best: best_q};

endmodule

### hdl/client_packet_tracking_table_top.sv
// Channel  | Signals                                          | Direction
// command  | start_i, busy_o, operation_i, ip_address_i,      | in
//          | port_i, packet_number_i                          |
// result   | done_o, status_o, flag_o, position_o,            | out
//          | packet_value_o, entry_count_o                    |
//
// An item is launched, then each valid entry passes in turn through the shared
// compare unit, and then the update is applied and the result is registered.
// done_o pulses for one cycle; busy_o is low in that cycle, so a new item may start.
// Reset empties the table; entry contents are not cleared.
// The receiver cannot stall: each result is shown exactly once.
module client_packet_tracking_table_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [3:0]        operation_i,
  input  logic [31:0]       ip_address_i,
  input  logic [15:0]       port_i,
  input  logic [7:0]        packet_number_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic              flag_o,
  output logic [4:0]        position_o,
  output logic signed [8:0] packet_value_o,
  output logic [4:0]        entry_count_o
);
  import ctpt_pkg::*;

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SScan = 3'b010,
    SExec = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q;
  logic [3:0]      op_q;
  logic [31:0]     addr_q;
  logic [15:0]     port_q;
  logic [7:0]      pk_q;
  logic            accept, scan_last;
  entry_t          rd_entry;
  wr_cmd_t         wr;
  scan_res_t       res;

  status_e         status_d;
  logic            flag_d;
  logic [4:0]      position_d;
  logic [8:0]      value_d;
  logic [MapBits-1:0] need;
  logic            pk_in_map;

  assign busy_o    = (state_q != SIdle);
  assign accept    = start_i && !busy_o;
  assign scan_last = (CntW'(idx_q) == count_q - CntW'(1));

  ctpt_store u_store (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_idx_i (idx_q),
    .rd_o     (rd_entry)
  );

  ctpt_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (accept),
    .step_i  (state_q == SScan),
    .idx_i   (idx_q),
    .entry_i (rd_entry),
    .op_i    (op_e'(op_q)),
    .addr_i  (addr_q),
    .port_i  (port_q),
    .pk_i    (pk_q),
    .res_o   (res)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (accept) state_d = (count_q == '0) ? SExec : SScan;
      SScan: if (scan_last) state_d = SExec;
      SExec: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Update and result of the finished scan.
  assign pk_in_map = (pk_q < 8'(MapBits));
  assign need = {MapBits{1'b1}} >> (MapIdxW'(MapBits - 1) - pk_q[MapIdxW-1:0]);

  always_comb begin
    wr         = '{kind: WrNone, idx: res.hit_idx, data: '0};
    status_d   = StOk;
    flag_d     = 1'b0;
    position_d = '0;
    value_d    = '0;
    count_d    = count_q;
    wr.data.addr = addr_q;
    wr.data.port = port_q;
    wr.data.pkt  = pk_q;
    case (op_q)
      OpInsert: begin
        if (count_q == CntW'(TableDepth)) status_d = StFull;
        else begin
          wr.kind = WrInsert;
          count_d = count_q + CntW'(1);
        end
      end
      OpDelete: begin
        if (!res.found) status_d = StNotFound;
        else begin
          wr.kind = WrDelete;
          count_d = count_q - CntW'(1);
        end
      end
      OpLocate: begin
        if (!res.found) status_d = StNotFound;
        else position_d = 5'(CntW'(res.hit_idx) + CntW'(1));
      end
      OpExists: flag_d = res.found;
      OpCount: ;
      OpGet: begin
        if (!res.found) begin
          status_d = StNotFound;
          value_d  = 9'h1FF;
        end else value_d = {1'b0, res.hit_pkt};
      end
      OpSet: begin
        if (!res.found) status_d = StNotFound;
        else wr.kind = WrPacket;
      end
      OpMin, OpMinExcl, OpMinGt, OpMax: begin
        if (count_q == '0) begin
          status_d = StEmpty;
          value_d  = 9'h1FF;
        end else if (res.have_best) value_d = {1'b0, res.best};
        else if (op_q == OpMinExcl) value_d = {1'b0, res.head_pkt};
        else value_d = {1'b0, pk_q};
      end
      OpSetBit: begin
        if (!res.found || !pk_in_map) status_d = StNotFound;
        else begin
          wr.kind     = WrMap;
          wr.data.map = res.hit_map | (MapBits'(1) << pk_q[MapIdxW-1:0]);
        end
      end
      OpClear: begin
        if (!res.found) status_d = StNotFound;
        else wr.kind = WrMap;
      end
      OpAll8: begin
        if (!res.found) status_d = StNotFound;
        else flag_d = &res.hit_map[7:0];
      end
      OpThrough: begin
        if (!res.found) status_d = StNotFound;
        else if (pk_in_map) flag_d = ((res.hit_map & need) == need);
      end
      default: status_d = StNotFound;
    endcase
    if (state_q != SExec) begin
      wr.kind = WrNone;
      count_d = count_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      done_o  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_o  <= (state_q == SExec);
      if (accept) idx_q <= '0;
      else if (state_q == SScan) idx_q <= idx_q + IdxW'(1);
    end
  end

  // Latched command and registered result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      addr_q <= ip_address_i;
      port_q <= port_i;
      pk_q   <= packet_number_i;
    end
    if (state_q == SExec) begin
      status_o       <= status_d;
      flag_o         <= flag_d;
      position_o     <= position_d;
      packet_value_o <= value_d;
      entry_count_o  <= 5'(count_d);
    end
  end

  // The table never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("entry count over depth");

  // A result follows the update step and leaves the block free.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  // A full report only happens on a full table.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StFull) |-> (count_q == CntW'(TableDepth)))
    else $error("full status on table with room");

  // The scan never runs past the valid entries.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> (CntW'(idx_q) < count_q)) else $error("scan out of range");

endmodule
